// File: rtl/core/mdc_pkg.sv
// ============================================================================
// mdc_pkg: shared types and constants of the message deduplication cache
// Holds the transaction structs, the status and register codes and the
// fixed field widths used by the cache core and the testbench.
// ============================================================================
package mdc_pkg;

  localparam int ADDR_W      = 32;
  localparam int PORT_W      = 16;
  localparam int MSG_ID_W    = 16;
  localparam int LEN_W       = 16;
  localparam int TIME_W      = 48;
  localparam int CAP_W       = 16;
  localparam int LIFE_W      = 32;
  localparam int SLOT_OUT_W  = 6;
  localparam int DROP_OUT_W  = 7;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_INDEX_W = 1;

  // A record size is header + length field + payload, rounded up; it fits in 17 bits.
  localparam int SIZE_W = 17;

  localparam logic [CAP_W-1:0]  CAP_RESET  = 16'd4096;
  localparam logic [LIFE_W-1:0] LIFE_RESET = 32'd247000;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_CAPACITY = 1'b0,
    CFG_LIFETIME = 1'b1
  } mdc_cfg_e;

  typedef enum logic {
    KIND_ADD = 1'b0,
    KIND_GET = 1'b1
  } mdc_kind_e;

  typedef enum logic [2:0] {
    STATUS_STORED    = 3'd0,
    STATUS_DUPLICATE = 3'd1,
    STATUS_TOO_LARGE = 3'd2,
    STATUS_HIT       = 3'd3,
    STATUS_MISS      = 3'd4
  } mdc_status_e;

  typedef struct packed {
    logic                kind;
    logic [ADDR_W-1:0]   peer_address;
    logic [PORT_W-1:0]   peer_port;
    logic [MSG_ID_W-1:0] message_id;
    logic [LEN_W-1:0]    message_length;
    logic [TIME_W-1:0]   current_time;
  } mdc_req_t;

  typedef struct packed {
    mdc_status_e           status;
    logic [SLOT_OUT_W-1:0] slot_index;
    logic [LEN_W-1:0]      found_length;
    logic [DROP_OUT_W-1:0] dropped_count;
  } mdc_rsp_t;

  // One stored record. The rounded size is kept so that a drop needs no recompute.
  typedef struct packed {
    logic [ADDR_W-1:0]   address;
    logic [PORT_W-1:0]   port;
    logic [MSG_ID_W-1:0] msg_id;
    logic [LEN_W-1:0]    length;
    logic [SIZE_W-1:0]   size;
    logic [TIME_W-1:0]   expiry;
  } mdc_entry_t;

endpackage

// File: rtl/core/message_dedup_cache_with_expiry.sv
// Each transaction is sized first; unless refused as oversized, it then checks the
//   oldest records for expiry, scans in age order and, on an add miss, evicts and
//   appends. The result is loaded last into the output register.
// Throughput: one transaction at a time; in_ready_o rises again once the result is
//   handed to the output register, which then waits for out_ready_i on its own.
// Reset: control state clears at once; record RAM contents are not cleared.
// ============================================================================
// message_dedup_cache_with_expiry: FIFO cache of sent-message records
// Records keyed by peer address, port and message ID live in a ring buffer
// with a byte budget. Bar oversized adds, a request drops expired leading
// records and looks the key up; an add miss evicts old ones and appends one.
// ============================================================================
module message_dedup_cache_with_expiry
  import mdc_pkg::*;
#(
  parameter int MAX_ENTRIES        = 64,
  parameter int HEADER_BYTES       = 24,
  parameter int LENGTH_FIELD_BYTES = 4,
  parameter int ALIGN_BYTES        = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Configuration writes
  input  logic                   cfg_we_i,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  // Request channel
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  mdc_req_t               in_req_i,
  // Response channel
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output mdc_rsp_t               out_rsp_o
);

  localparam int SLOT_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);

  // Rounding to ALIGN_BYTES uses a reciprocal multiply. The quotient estimate is
  // at most one short, so a single compare and subtract corrects the remainder.
  localparam int RECIP_SHIFT = 18;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int RECIP       = (1 << RECIP_SHIFT) / ALIGN_BYTES;
  localparam int PROD_W      = SIZE_W + RECIP_W;
  localparam int ALIGN_W     = 7;
  localparam int QA_W        = SIZE_W + ALIGN_W;

  // Sequencer states, one-hot.
  typedef enum logic [10:0] {
    ST_IDLE       = 11'b000_0000_0001,
    ST_SIZE_Q     = 11'b000_0000_0010,
    ST_SIZE_R     = 11'b000_0000_0100,
    ST_SIZE_F     = 11'b000_0000_1000,
    ST_EXP_RD     = 11'b000_0001_0000,
    ST_EXP_CHK    = 11'b000_0010_0000,
    ST_SCAN       = 11'b000_0100_0000,
    ST_EVICT_CHK  = 11'b000_1000_0000,
    ST_EVICT_DROP = 11'b001_0000_0000,
    ST_APPEND     = 11'b010_0000_0000,
    ST_DONE       = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [CAP_W-1:0]  cap_q;
  logic [LIFE_W-1:0] life_q;

  // FIFO bookkeeping.
  logic [SLOT_W-1:0] oldest_q, oldest_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CAP_W-1:0]  bytes_q, bytes_d;

  // Per-transaction working registers.
  logic [CNT_W-1:0]  dropped_q, dropped_d;
  logic [CNT_W-1:0]  pos_q, pos_d;
  logic              cmp_valid_q, cmp_valid_d;
  logic [SLOT_W-1:0] cmp_slot_q, cmp_slot_d;
  mdc_req_t          item_q, item_d;
  logic [SIZE_W-1:0] q_est_q, q_est_d;
  logic [SIZE_W-1:0] rem_q, rem_d;
  logic [SIZE_W-1:0] req_q, req_d;
  mdc_rsp_t          res_q, res_d;

  // Output register.
  logic              out_valid_q, out_valid_d;
  mdc_rsp_t          out_q, out_d;

  // Record RAM port signals.
  logic              ram_we;
  logic [SLOT_W-1:0] ram_waddr;
  mdc_entry_t        ram_wdata;
  logic              ram_re;
  logic [SLOT_W-1:0] ram_raddr;
  mdc_entry_t        ram_rdata;

  // Size unit and datapath helpers.
  logic [SIZE_W-1:0] raw_size;
  logic [PROD_W-1:0] recip_prod;
  logic [QA_W-1:0]   q_times_a;
  logic [SIZE_W-1:0] rem_raw;
  logic [SIZE_W-1:0] req_size;
  logic [CAP_W-1:0]  free_bytes;
  logic              key_match;
  logic              expired;

  // Advance a slot around the circular buffer; the sum stays below 2*MAX_ENTRIES.
  function automatic logic [SLOT_W-1:0] slot_add(logic [SLOT_W-1:0] base,
                                                 logic [CNT_W-1:0]  off);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
    if (sum >= (CNT_W+1)'(MAX_ENTRIES)) begin
      sum = sum - (CNT_W+1)'(MAX_ENTRIES);
    end
    return sum[SLOT_W-1:0];
  endfunction

  mdc_ram #(
    .WIDTH ($bits(mdc_entry_t)),
    .DEPTH (MAX_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // The record size is header plus length field plus payload, rounded up to the
  // alignment. It takes three steps: quotient estimate, remainder, round-up.
  assign raw_size   = SIZE_W'(HEADER_BYTES) + SIZE_W'(LENGTH_FIELD_BYTES)
                    + SIZE_W'(item_q.message_length);
  assign recip_prod = PROD_W'(raw_size) * PROD_W'(RECIP);
  assign q_times_a  = QA_W'(q_est_q) * QA_W'(ALIGN_BYTES);
  assign rem_raw    = raw_size - q_times_a[SIZE_W-1:0];
  assign req_size   = (rem_q == '0) ? raw_size
                                    : raw_size + SIZE_W'(ALIGN_BYTES) - rem_q;

  // Free space counts as zero when capacity has been lowered below what is in use.
  assign free_bytes = (cap_q > bytes_q) ? cap_q - bytes_q : '0;

  assign key_match = (ram_rdata.msg_id == item_q.message_id) &&
                     (ram_rdata.address == item_q.peer_address) &&
                     (ram_rdata.port == item_q.peer_port);
  assign expired   = ram_rdata.expiry < item_q.current_time;

  always_comb begin
    state_d     = state_q;
    oldest_d    = oldest_q;
    count_d     = count_q;
    bytes_d     = bytes_q;
    dropped_d   = dropped_q;
    pos_d       = pos_q;
    cmp_valid_d = cmp_valid_q;
    cmp_slot_d  = cmp_slot_q;
    item_d      = item_q;
    q_est_d     = q_est_q;
    rem_d       = rem_q;
    req_d       = req_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;

    ram_we    = 1'b0;
    ram_waddr = slot_add(oldest_q, count_q);
    ram_re    = 1'b0;
    ram_raddr = oldest_q;

    ram_wdata.address = item_q.peer_address;
    ram_wdata.port    = item_q.peer_port;
    ram_wdata.msg_id  = item_q.message_id;
    ram_wdata.length  = item_q.message_length;
    ram_wdata.size    = req_q;
    ram_wdata.expiry  = item_q.current_time + TIME_W'(life_q);

    // The consumer drains the output register independently of the sequencer.
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          item_d      = in_req_i;
          dropped_d   = '0;
          pos_d       = '0;
          cmp_valid_d = 1'b0;
          state_d     = ST_SIZE_Q;
        end
      end

      ST_SIZE_Q: begin
        q_est_d = recip_prod[RECIP_SHIFT +: SIZE_W];
        state_d = ST_SIZE_R;
      end

      ST_SIZE_R: begin
        rem_d   = (rem_raw >= SIZE_W'(ALIGN_BYTES)) ? rem_raw - SIZE_W'(ALIGN_BYTES)
                                                    : rem_raw;
        state_d = ST_SIZE_F;
      end

      ST_SIZE_F: begin
        req_d = req_size;
        // An oversized add is refused before anything expires.
        if (item_q.kind == KIND_ADD && req_size > SIZE_W'(cap_q)) begin
          res_d.status        = STATUS_TOO_LARGE;
          res_d.slot_index    = '0;
          res_d.found_length  = '0;
          res_d.dropped_count = '0;
          state_d             = ST_DONE;
        end else begin
          state_d = ST_EXP_RD;
        end
      end

      ST_EXP_RD: begin
        if (count_q == '0) begin
          state_d = ST_SCAN;
        end else begin
          ram_re  = 1'b1;
          state_d = ST_EXP_CHK;
        end
      end

      ST_EXP_CHK: begin
        if (expired) begin
          bytes_d   = (SIZE_W'(bytes_q) >= ram_rdata.size)
                    ? bytes_q - ram_rdata.size[CAP_W-1:0] : '0;
          oldest_d  = slot_add(oldest_q, CNT_W'(1));
          count_d   = count_q - CNT_W'(1);
          dropped_d = dropped_q + CNT_W'(1);
          state_d   = ST_EXP_RD;
        end else begin
          state_d = ST_SCAN;
        end
      end

      // Reads are issued one per cycle from the oldest record on; each read is
      // compared the cycle after, so the first match in age order wins.
      ST_SCAN: begin
        if (cmp_valid_q && key_match) begin
          res_d.slot_index    = SLOT_OUT_W'(cmp_slot_q);
          res_d.dropped_count = DROP_OUT_W'(dropped_q);
          if (item_q.kind == KIND_ADD) begin
            res_d.status       = STATUS_DUPLICATE;
            res_d.found_length = '0;
          end else begin
            res_d.status       = STATUS_HIT;
            res_d.found_length = ram_rdata.length;
          end
          state_d = ST_DONE;
        end else if (pos_q < count_q) begin
          ram_re      = 1'b1;
          ram_raddr   = slot_add(oldest_q, pos_q);
          cmp_slot_d  = slot_add(oldest_q, pos_q);
          cmp_valid_d = 1'b1;
          pos_d       = pos_q + CNT_W'(1);
        end else if (cmp_valid_q) begin
          cmp_valid_d = 1'b0;
        end else if (item_q.kind == KIND_ADD) begin
          state_d = ST_EVICT_CHK;
        end else begin
          res_d.status        = STATUS_MISS;
          res_d.slot_index    = '0;
          res_d.found_length  = '0;
          res_d.dropped_count = DROP_OUT_W'(dropped_q);
          state_d             = ST_DONE;
        end
      end

      ST_EVICT_CHK: begin
        if (count_q == '0 ||
            (SIZE_W'(free_bytes) >= req_q && count_q < CNT_W'(MAX_ENTRIES))) begin
          state_d = ST_APPEND;
        end else begin
          ram_re  = 1'b1;
          state_d = ST_EVICT_DROP;
        end
      end

      ST_EVICT_DROP: begin
        bytes_d   = (SIZE_W'(bytes_q) >= ram_rdata.size)
                  ? bytes_q - ram_rdata.size[CAP_W-1:0] : '0;
        oldest_d  = slot_add(oldest_q, CNT_W'(1));
        count_d   = count_q - CNT_W'(1);
        dropped_d = dropped_q + CNT_W'(1);
        state_d   = ST_EVICT_CHK;
      end

      ST_APPEND: begin
        ram_we              = 1'b1;
        count_d             = count_q + CNT_W'(1);
        bytes_d             = bytes_q + req_q[CAP_W-1:0];
        res_d.status        = STATUS_STORED;
        res_d.slot_index    = SLOT_OUT_W'(ram_waddr);
        res_d.found_length  = '0;
        res_d.dropped_count = DROP_OUT_W'(dropped_q);
        state_d             = ST_DONE;
      end

      // Hand the result over once the output register is free or being drained.
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cap_q       <= CAP_RESET;
      life_q      <= LIFE_RESET;
      oldest_q    <= '0;
      count_q     <= '0;
      bytes_q     <= '0;
      dropped_q   <= '0;
      pos_q       <= '0;
      cmp_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      oldest_q    <= oldest_d;
      count_q     <= count_d;
      bytes_q     <= bytes_d;
      dropped_q   <= dropped_d;
      pos_q       <= pos_d;
      cmp_valid_q <= cmp_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_CAPACITY) begin
          cap_q <= cfg_data_i[CAP_W-1:0];
        end else if (cfg_index_i == CFG_LIFETIME) begin
          life_q <= cfg_data_i[LIFE_W-1:0];
        end
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    item_d_latch: begin
      item_q     <= item_d;
      q_est_q    <= q_est_d;
      rem_q      <= rem_d;
      req_q      <= req_d;
      res_q      <= res_d;
      cmp_slot_q <= cmp_slot_d;
      out_q      <= out_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // The FIFO never holds more records than it has slots.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_ENTRIES))
    else $error("record count exceeds the number of slots");

  // Bytes in use are exactly the sizes of the live records, so an empty FIFO uses none.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (bytes_q == '0))
    else $error("empty cache still accounts bytes");

  // An append only happens with a free slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_APPEND) |-> (count_q < CNT_W'(MAX_ENTRIES)))
    else $error("append into a full cache");

  // A finished result with a free output register moves into it on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && !out_valid_q) |=> (state_q == ST_IDLE && out_valid_q))
    else $error("result not handed to the output register");

  // The oldest pointer always names a real slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (SLOT_W+1)'(oldest_q) < (SLOT_W+1)'(MAX_ENTRIES))
    else $error("oldest slot out of range");

endmodule

// File: rtl/core/mdc_ram.sv
// ============================================================================
// mdc_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; contents are not reset.
// ============================================================================
module mdc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top: regression for the message deduplication cache with expiry
// Drives add and lookup transactions through the request channel, predicts
// every response but those of typed directed rows with an independent mirror
// of the record FIFO, its byte budget and its expiry rules, and compares each
// response field by field. A short directed table comes first. Random phases
// follow, each under its own capacity and lifetime, with idling on both channels until STOP_IDLE_AT.
// ============================================================================
module tb_top;
  import mdc_pkg::*;

  // Geometry of the cache as instantiated with its default parameters.
  localparam int unsigned SLOTS      = 64;
  localparam int unsigned HDR_BYTES  = 24;
  localparam int unsigned LENF_BYTES = 4;
  localparam int unsigned ALIGN      = 8;

  // Longest stretch without any transaction before the run is declared hung.
  // Beyond the slowest transaction in the block, the rest is headroom for
  // long random stalls on either channel.
  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned DRAIN_CYCLES = 3 * SLOTS + 40;

  // Idling switches from sender-light to receiver-light and then stops.
  localparam int unsigned SWAP_IDLE_AT = 620;
  localparam int unsigned STOP_IDLE_AT = 1245;

  localparam int unsigned KEY_POOL = 24;

  typedef struct {
    mdc_req_t req;
    bit       typed;
    mdc_rsp_t rsp;
  } stim_row_t;

  typedef struct {
    logic [ADDR_W-1:0]   addr;
    logic [PORT_W-1:0]   port;
    logic [MSG_ID_W-1:0] id;
  } peer_key_t;

  logic                   clk_i;
  logic                   rst_ni      = 1'b0;
  logic                   cfg_we_i    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i  = '0;
  logic                   in_valid_i  = 1'b0;
  logic                   in_ready_o;
  mdc_req_t               in_req_i    = '0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  mdc_rsp_t               out_rsp_o;

  message_dedup_cache_with_expiry dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Mirror of the cache. Live records occupy slots cache_head, cache_head+1,
  // ... modulo SLOTS, cache_count of them, oldest first.
  // --------------------------------------------------------------------------
  logic [ADDR_W-1:0]   cache_addr [SLOTS];
  logic [PORT_W-1:0]   cache_port [SLOTS];
  logic [MSG_ID_W-1:0] cache_id   [SLOTS];
  logic [LEN_W-1:0]    cache_len  [SLOTS];
  logic [TIME_W-1:0]   cache_exp  [SLOTS];
  int unsigned         cache_head  = 0;
  int unsigned         cache_count = 0;
  int unsigned         cache_bytes = 0;

  int unsigned         cfg_capacity = 32'(CAP_RESET);
  logic [LIFE_W-1:0]   cfg_lifetime = LIFE_RESET;

  mdc_rsp_t    predicted_replies[$];
  int unsigned mismatches    = 0;
  int unsigned items_sent    = 0;
  int unsigned stall_cycles  = 0;
  int unsigned send_idle_pct = 31;
  int unsigned recv_idle_pct = 83;

  logic [TIME_W-1:0] clock_ticks = '0;
  peer_key_t         key_pool[KEY_POOL];
  stim_row_t         directed_rows[$];

  // A record costs its header, its length field and its payload, rounded up
  // to the alignment.
  function automatic int unsigned rec_bytes(logic [LEN_W-1:0] len);
    int unsigned raw;
    raw = HDR_BYTES + LENF_BYTES + 32'(len);
    return ((raw + ALIGN - 1) / ALIGN) * ALIGN;
  endfunction

  function automatic void retire_head();
    int unsigned sz;
    sz = rec_bytes(cache_len[cache_head]);
    cache_bytes = (cache_bytes >= sz) ? cache_bytes - sz : 0;
    cache_head  = (cache_head + 1) % SLOTS;
    cache_count--;
  endfunction

  // Only leading records can expire; a record whose expiry equals the
  // current time is still live.
  function automatic int unsigned purge_expired(logic [TIME_W-1:0] now);
    int unsigned n;
    n = 0;
    while (cache_count > 0 && cache_exp[cache_head] < now) begin
      retire_head();
      n++;
    end
    return n;
  endfunction

  function automatic bit lookup_key(peer_key_t k, output int unsigned slot);
    int unsigned s;
    slot = 0;
    for (int unsigned i = 0; i < cache_count; i++) begin
      s = (cache_head + i) % SLOTS;
      if (cache_id[s] == k.id && cache_addr[s] == k.addr && cache_port[s] == k.port) begin
        slot = s;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Applies one transaction to the mirror and returns the response it owes.
  function automatic mdc_rsp_t dedup_predict(mdc_req_t r);
    mdc_rsp_t    rsp;
    peer_key_t   k;
    int unsigned need;
    int unsigned slot;
    int unsigned spare;
    int unsigned dropped;
    rsp     = '0;
    k.addr  = r.peer_address;
    k.port  = r.peer_port;
    k.id    = r.message_id;
    dropped = 0;
    slot    = 0;
    if (r.kind == KIND_ADD) begin
      need = rec_bytes(r.message_length);
      // An oversized record is refused before anything expires.
      if (need > cfg_capacity) begin
        rsp.status = STATUS_TOO_LARGE;
      end else begin
        dropped = purge_expired(r.current_time);
        if (lookup_key(k, slot)) begin
          rsp.status     = STATUS_DUPLICATE;
          rsp.slot_index = slot[SLOT_OUT_W-1:0];
        end else begin
          // Evict the oldest records until both bytes and a slot are free.
          // A capacity below the bytes in use counts as no free space.
          forever begin
            spare = (cfg_capacity > cache_bytes) ? cfg_capacity - cache_bytes : 0;
            if (cache_count == 0 || (spare >= need && cache_count < SLOTS)) break;
            retire_head();
            dropped++;
          end
          slot = (cache_head + cache_count) % SLOTS;
          cache_addr[slot] = k.addr;
          cache_port[slot] = k.port;
          cache_id[slot]   = k.id;
          cache_len[slot]  = r.message_length;
          // The expiry wraps at the time width.
          cache_exp[slot]  = r.current_time + TIME_W'(cfg_lifetime);
          cache_count++;
          cache_bytes += need;
          rsp.status     = STATUS_STORED;
          rsp.slot_index = slot[SLOT_OUT_W-1:0];
        end
      end
    end else begin
      dropped = purge_expired(r.current_time);
      if (lookup_key(k, slot)) begin
        rsp.status       = STATUS_HIT;
        rsp.slot_index   = slot[SLOT_OUT_W-1:0];
        rsp.found_length = cache_len[slot];
      end else begin
        rsp.status = STATUS_MISS;
      end
    end
    rsp.dropped_count = dropped[DROP_OUT_W-1:0];
    return rsp;
  endfunction

  function automatic stim_row_t dir_row(mdc_kind_e kind, logic [ADDR_W-1:0] addr,
                                        logic [PORT_W-1:0] port, logic [MSG_ID_W-1:0] id,
                                        logic [LEN_W-1:0] len, logic [TIME_W-1:0] now,
                                        bit typed = 1'b0,
                                        mdc_status_e st = STATUS_STORED,
                                        logic [SLOT_OUT_W-1:0] slot = '0,
                                        logic [LEN_W-1:0] flen = '0,
                                        logic [DROP_OUT_W-1:0] drop = '0);
    stim_row_t row;
    row.req.kind           = kind;
    row.req.peer_address   = addr;
    row.req.peer_port      = port;
    row.req.message_id     = id;
    row.req.message_length = len;
    row.req.current_time   = now;
    row.typed              = typed;
    row.rsp.status         = st;
    row.rsp.slot_index     = slot;
    row.rsp.found_length   = flen;
    row.rsp.dropped_count  = drop;
    return row;
  endfunction

  // --------------------------------------------------------------------------
  // Request side. Each call starts and ends on a rising edge. Valid stays
  // high from one transaction to the next unless the sender idles, so it is
  // never lowered and raised within the same time step.
  // --------------------------------------------------------------------------
  task automatic put_request(mdc_req_t r, bit typed = 1'b0, mdc_rsp_t typed_rsp = '0);
    mdc_rsp_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    // Outputs are read right after the edge, before the block's own
    // registers update, so this sees the ready of the accepting edge.
    do @(posedge clk_i); while (!in_ready_o);
    predicted = dedup_predict(r);
    predicted_replies.push_back(typed ? typed_rsp : predicted);
    items_sent++;
    if (items_sent == SWAP_IDLE_AT) begin
      send_idle_pct = 83;
      recv_idle_pct = 31;
    end else if (items_sent == STOP_IDLE_AT) begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  endtask

  // Lowers valid in the step of the last acceptance and waits until every
  // response is back, which leaves the block idle.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (predicted_replies.size() != 0) @(posedge clk_i);
  endtask

  // Writes the capacity register, then the lifetime register; the mirror follows.
  task automatic write_config(int unsigned cap, logic [LIFE_W-1:0] life);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_CAPACITY;
    cfg_data_i  <= CFG_DATA_W'(cap);
    @(posedge clk_i);
    cfg_capacity = cap & 32'hFFFF;
    cfg_index_i <= CFG_LIFETIME;
    cfg_data_i  <= CFG_DATA_W'(life);
    @(posedge clk_i);
    cfg_lifetime = life;
    cfg_we_i    <= 1'b0;
  endtask

  // One random phase. Most transactions reuse a small pool of keys so that
  // duplicates and hits are common; the rest use fresh keys, which fill the
  // slots and give misses. Lengths are mostly small with some of full range.
  task automatic run_phase(int unsigned cap, logic [LIFE_W-1:0] life, int unsigned n,
                           int unsigned step_max, int unsigned len_max);
    mdc_req_t  r;
    peer_key_t k;
    wait_drained();
    write_config(cap, life);
    repeat (n) begin
      if ($urandom_range(0, 99) < 60) begin
        k = key_pool[$urandom_range(0, KEY_POOL - 1)];
      end else begin
        k.addr = $urandom;
        k.port = PORT_W'($urandom_range(0, 65535));
        k.id   = MSG_ID_W'($urandom_range(0, 65535));
      end
      clock_ticks += TIME_W'($urandom_range(0, step_max));
      // Now and then time leaps ahead by a random amount, which can flush the cache.
      if ($urandom_range(0, 99) < 2) clock_ticks += TIME_W'($urandom);
      r.kind           = ($urandom_range(0, 99) < 55) ? KIND_ADD : KIND_GET;
      r.peer_address   = k.addr;
      r.peer_port      = k.port;
      r.message_id     = k.id;
      r.message_length = ($urandom_range(0, 99) < 85) ? LEN_W'($urandom_range(0, len_max))
                                                      : LEN_W'($urandom_range(0, 65535));
      r.current_time   = clock_ticks;
      put_request(r);
    end
  endtask

  task automatic report_mismatch(string what, mdc_rsp_t want, mdc_rsp_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display({"[%0t] %s: want st=%0d slot=%0d len=%0d drop=%0d,",
                " got st=%0d slot=%0d len=%0d drop=%0d"},
               $realtime, what, want.status, want.slot_index, want.found_length,
               want.dropped_count, got.status, got.slot_index, got.found_length,
               got.dropped_count);
    end
  endtask

  // --------------------------------------------------------------------------
  // Response side: every accepted response is checked against the oldest
  // prediction, then ready is redrawn for the next cycle.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : rsp_check
    mdc_rsp_t want_rsp;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (predicted_replies.size() == 0) begin
        report_mismatch("response with no transaction outstanding", '0, out_rsp_o);
      end else begin
        want_rsp = predicted_replies.pop_front();
        if (out_rsp_o.status !== want_rsp.status ||
            out_rsp_o.slot_index !== want_rsp.slot_index ||
            out_rsp_o.found_length !== want_rsp.found_length ||
            out_rsp_o.dropped_count !== want_rsp.dropped_count) begin
          report_mismatch("response mismatch", want_rsp, out_rsp_o);
        end
      end
    end
    out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Watchdog: any transaction on either channel restarts the count.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("message_dedup_cache_with_expiry regression: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    // Directed table under the reset configuration (4096 bytes, lifetime
    // 247000). Typed rows are obvious from the rules; the others go through
    // the mirror.
    directed_rows.push_back(dir_row(KIND_GET, '0, '0, '0, '0, '0,
                                    1'b1, STATUS_MISS));
    directed_rows.push_back(dir_row(KIND_ADD, '1, '1, '1, '1, '0,
                                    1'b1, STATUS_TOO_LARGE));
    directed_rows.push_back(dir_row(KIND_ADD, '1, '1, '1, '0, '0,
                                    1'b1, STATUS_STORED));
    directed_rows.push_back(dir_row(KIND_ADD, '1, '1, '1, 16'd100, 48'd1,
                                    1'b1, STATUS_DUPLICATE));
    directed_rows.push_back(dir_row(KIND_GET, '1, '1, '1, '0, 48'd2,
                                    1'b1, STATUS_HIT));
    // A record of exactly the capacity forces the first one out.
    directed_rows.push_back(dir_row(KIND_ADD, '0, '0, '0, 16'd4068, 48'd3));
    // Expiry equal to now is still live; one tick later it is gone.
    directed_rows.push_back(dir_row(KIND_GET, '0, '0, '0, '0, 48'd247003));
    directed_rows.push_back(dir_row(KIND_GET, '0, '0, '0, '0, 48'd247004));
    // Keys differing in one part only must not match.
    directed_rows.push_back(dir_row(KIND_ADD, 32'h1234_5678, 16'h5555, 16'hAAAA, 16'd1,
                                    48'd247004));
    directed_rows.push_back(dir_row(KIND_ADD, 32'h1234_5678, 16'h5555, 16'hAAAB, 16'd7,
                                    48'd247005));
    directed_rows.push_back(dir_row(KIND_ADD, 32'h1234_5678, 16'hAAAA, 16'hAAAA, 16'h00FF,
                                    48'd247006));
    directed_rows.push_back(dir_row(KIND_GET, 32'h1234_5678, 16'h5555, 16'hAAAA, '0,
                                    48'd247007));
    directed_rows.push_back(dir_row(KIND_GET, 32'h1234_5679, 16'h5555, 16'hAAAA, '0,
                                    48'd247008));
    // Full-size record evicts everything before it.
    directed_rows.push_back(dir_row(KIND_ADD, 32'h8000_0001, 16'h8000, 16'h0001, 16'd4068,
                                    48'd247009));
    directed_rows.push_back(dir_row(KIND_GET, 32'h8000_0001, 16'h8000, 16'h0001, '0,
                                    48'h8000_0000_0000));
    // One alignment step over the capacity.
    directed_rows.push_back(dir_row(KIND_ADD, 32'h0F0F_0F0F, 16'h0F0F, 16'h0F0F, 16'd4069,
                                    48'h8000_0000_0001, 1'b1, STATUS_TOO_LARGE));
    // The expiry of a record stored at the end of time wraps to a small
    // value, so the same record has expired at once.
    directed_rows.push_back(dir_row(KIND_ADD, 32'hF0F0_F0F0, 16'hF0F0, 16'hF0F0, '0, '1));
    directed_rows.push_back(dir_row(KIND_GET, 32'hF0F0_F0F0, 16'hF0F0, 16'hF0F0, '0, '1));

    for (int unsigned i = 0; i < KEY_POOL; i++) begin
      key_pool[i].addr = $urandom;
      key_pool[i].port = PORT_W'($urandom_range(0, 65535));
      key_pool[i].id   = MSG_ID_W'($urandom_range(0, 65535));
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      put_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].rsp);
    end

    // Slots fill before bytes run out, so the slot limit drives eviction.
    clock_ticks = 48'h1000;
    run_phase(4096, 32'd100000, 350, 300, 40);
    // Capacity drops below the bytes in use and lifetimes are short.
    run_phase(256, 32'd2000, 300, 100, 60);
    // A capacity of one byte: every add is refused.
    run_phase(1, 32'd5000, 60, 50, 40);
    // Largest settings, with time running over its top so expiries wrap.
    clock_ticks = 48'hFFFF_FFFE_7960;
    run_phase(65535, 32'hFFFF_FFFF, 350, 1000, 2000);
    // Zero lifetime with slow time: records live only while time stands.
    run_phase(600, 32'd0, 300, 2, 100);
    run_phase($urandom_range(200, 8000), $urandom_range(0, 20000), 490, 200, 300);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && predicted_replies.size() == 0) begin
      $display("message_dedup_cache_with_expiry regression: pass");
    end else begin
      $display("message_dedup_cache_with_expiry regression: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/mdc_pkg.sv
rtl/core/mdc_ram.sv
rtl/core/message_dedup_cache_with_expiry.sv
tb/sv/tb_top.sv
